// File: design/cbq_pkg.sv
// Package for the cascaded biquad filter: fixed-point types, register
// codes and reset values, and the rounding and saturation helpers.
// No dependencies.
package cbq_pkg;

  localparam int SECTIONS     = 3;
  localparam int COEF_WIDTH   = 16;
  localparam int SAMPLE_WIDTH = 16;
  localparam int SIG_W        = 32;
  localparam int SIG_FRAC     = 12;
  localparam int CF           = COEF_WIDTH - 3;
  localparam int PROD_W       = SIG_W + COEF_WIDTH;
  localparam int WIDE_W       = PROD_W + 4;
  localparam int SEC_W        = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int DLY_W        = $clog2(2 * SECTIONS);
  localparam int NUM_BANKS    = 3;

  typedef logic signed [15:0]           sample_t;
  typedef logic signed [SIG_W-1:0]      sig_t;
  typedef logic signed [COEF_WIDTH-1:0] coef_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [WIDE_W-1:0]     wide_t;

  // Configuration register indexes
  localparam logic [2:0] CFG_S0_NUM = 3'd0;
  localparam logic [2:0] CFG_S0_DEN = 3'd1;
  localparam logic [2:0] CFG_S1_NUM = 3'd2;
  localparam logic [2:0] CFG_S1_DEN = 3'd3;
  localparam logic [2:0] CFG_S2_NUM = 3'd4;
  localparam logic [2:0] CFG_S2_DEN = 3'd5;
  localparam logic [2:0] CFG_GAIN   = 3'd6;

  localparam logic [47:0] S0_NUM_RST = 48'd246290604630016;
  localparam logic [31:0] S0_DEN_RST = 32'd70775855;
  localparam logic [47:0] S1_NUM_RST = 48'd35185445838848;
  localparam logic [31:0] S1_DEN_RST = 32'd284823666;
  localparam logic [47:0] S2_NUM_RST = 48'd35187593322496;
  localparam logic [31:0] S2_DEN_RST = 32'd352966408;
  localparam logic [63:0] GAIN_RST   = 64'd2305878194122654585;

  // Signed coefficient field; bits beyond the register read as zero.
  function automatic coef_t coef_field(input logic [63:0] r, input logic [1:0] idx);
    logic [63+4*COEF_WIDTH:0] ext;
    ext = {{(4*COEF_WIDTH){1'b0}}, r};
    return $signed(ext[idx*COEF_WIDTH +: COEF_WIDTH]);
  endfunction

  // Add half an LSB, then floor.
  function automatic wide_t rnd_shift(input wide_t v, input int unsigned sh);
    wide_t t;
    t = v + (wide_t'(1) <<< (sh - 1));
    return t >>> sh;
  endfunction

  function automatic sig_t sat_sig(input wide_t v);
    if (&v[WIDE_W-1:SIG_W-1] || ~|v[WIDE_W-1:SIG_W-1]) begin
      return v[SIG_W-1:0];
    end else if (v[WIDE_W-1]) begin
      return {1'b1, {(SIG_W-1){1'b0}}};
    end else begin
      return {1'b0, {(SIG_W-1){1'b1}}};
    end
  endfunction

  function automatic sig_t in_conv(input sample_t s);
    logic [31:0] raw;
    wide_t       x;
    raw = {16'b0, s};
    x = wide_t'($signed(raw[SAMPLE_WIDTH-1:0]));
    return sat_sig(x <<< SIG_FRAC);
  endfunction

  function automatic sample_t out_conv(input wide_t v);
    wide_t o;
    wide_t c;
    o = rnd_shift(v, CF + SIG_FRAC);
    if (&o[WIDE_W-1:SAMPLE_WIDTH-1] || ~|o[WIDE_W-1:SAMPLE_WIDTH-1]) begin
      c = o;
    end else if (o[WIDE_W-1]) begin
      c = -(wide_t'(1) <<< (SAMPLE_WIDTH - 1));
    end else begin
      c = (wide_t'(1) <<< (SAMPLE_WIDTH - 1)) - wide_t'(1);
    end
    return $signed(c[15:0]);
  endfunction

endpackage

// File: design/cbq_ifs.sv
// Stream interfaces for the biquad filter: valid/ready plus sample payload.
// Depends on cbq_pkg.
interface cbq_in_if;
  logic             valid;
  logic             ready;
  cbq_pkg::sample_t sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface cbq_out_if;
  logic             valid;
  logic             ready;
  cbq_pkg::sample_t sample_out;
  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

// File: design/cascaded_biquad_iir_filter.sv
// Three-section direct-form-I biquad cascade on one shared 32x16 multiplier.
// One item in flight: a new input is taken only once the previous one has
// passed through every section and the output gain, the pace being set by
// the single multiply-accumulate unit. Output register frees the next input.
// Reset (rst_n, synchronous): delay lines cleared, registers to defaults.
// Depends on cbq_pkg and cbq_ifs.
module cascaded_biquad_iir_filter (
  input  logic               clk,
  input  logic               rst_n,
  cbq_in_if.sink             in_ch,
  cbq_out_if.source          out_ch,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_wdata
);
  import cbq_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MAC  = 3'd1;
  localparam logic [2:0] ST_RND1 = 3'd2;
  localparam logic [2:0] ST_GMUL = 3'd3;
  localparam logic [2:0] ST_RND2 = 3'd4;
  localparam logic [2:0] ST_OMUL = 3'd5;
  localparam logic [2:0] ST_ORND = 3'd6;

  localparam logic [2:0] TAP_LAST = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic [SEC_W-1:0] sec_r, sec_nxt;
  logic [2:0]       tap_r, tap_nxt;
  sig_t             sig_r, sig_nxt;
  sig_t             r_r, r_nxt;
  wide_t            acc_r, acc_nxt;
  prod_t            prod_r, prod_nxt;
  logic             prod_en;
  sig_t             xd_r [2*SECTIONS];
  sig_t             xd_nxt [2*SECTIONS];
  sig_t             yd_r [2*SECTIONS];
  sig_t             yd_nxt [2*SECTIONS];
  logic             out_valid_r, out_valid_nxt;
  sample_t          out_data_r, out_data_nxt;

  logic [47:0]      num_r [NUM_BANKS];
  logic [31:0]      den_r [NUM_BANKS];
  logic [63:0]      gain_r;

  sig_t             mul_a;
  coef_t            mul_b;
  logic [DLY_W-1:0] dly_idx;
  logic             odd_tap;
  logic             accept;
  logic             slot_free;
  sig_t             yv;
  logic [63:0]      num_sel;
  logic [63:0]      den_sel;

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign accept            = in_ch.valid && in_ch.ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.sample_out = out_data_r;
  assign slot_free         = !out_valid_r || out_ch.ready;

  assign num_sel = {16'b0, num_r[sec_r]};
  assign den_sel = {32'b0, den_r[sec_r]};
  assign odd_tap = (tap_r == 3'd2) || (tap_r == 3'd4);
  assign dly_idx = DLY_W'({sec_r, odd_tap});
  assign yv      = sat_sig(rnd_shift(wide_t'(prod_r), CF));

  // Operand select for the shared multiplier
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    prod_en = 1'b0;
    unique case (state_r)
      ST_MAC: begin
        prod_en = (tap_r != TAP_LAST);
        unique case (tap_r)
          3'd0: begin
            mul_a = sig_r;
            mul_b = coef_field(num_sel, 2'd0);
          end
          3'd1: begin
            mul_a = xd_r[dly_idx];
            mul_b = coef_field(num_sel, 2'd1);
          end
          3'd2: begin
            mul_a = xd_r[dly_idx];
            mul_b = coef_field(num_sel, 2'd2);
          end
          3'd3: begin
            mul_a = yd_r[dly_idx];
            mul_b = coef_field(den_sel, 2'd0);
          end
          3'd4: begin
            mul_a = yd_r[dly_idx];
            mul_b = coef_field(den_sel, 2'd1);
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      ST_GMUL: begin
        prod_en = 1'b1;
        mul_a   = r_r;
        mul_b   = coef_field(gain_r, 2'(sec_r));
      end
      ST_OMUL: begin
        prod_en = 1'b1;
        mul_a   = sig_r;
        mul_b   = coef_field(gain_r, 2'd3);
      end
      default: begin
        prod_en = 1'b0;
      end
    endcase
    prod_nxt = prod_t'(mul_a) * prod_t'(mul_b);
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    sec_nxt       = sec_r;
    tap_nxt       = tap_r;
    sig_nxt       = sig_r;
    r_nxt         = r_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    for (int i = 0; i < 2*SECTIONS; i++) begin
      xd_nxt[i] = xd_r[i];
      yd_nxt[i] = yd_r[i];
    end
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          sig_nxt   = in_conv(in_ch.sample_in);
          sec_nxt   = '0;
          tap_nxt   = '0;
          state_nxt = ST_MAC;
        end
      end
      ST_MAC: begin
        // product of tap t-1 lands while tap t is issued; feedback terms subtract
        if (tap_r == 3'd0) begin
          acc_nxt = '0;
        end else if (tap_r >= 3'd4) begin
          acc_nxt = acc_r - wide_t'(prod_r);
        end else begin
          acc_nxt = acc_r + wide_t'(prod_r);
        end
        if (tap_r == TAP_LAST) begin
          state_nxt = ST_RND1;
        end else begin
          tap_nxt = tap_r + 3'd1;
        end
      end
      ST_RND1: begin
        r_nxt     = sat_sig(rnd_shift(acc_r, CF));
        state_nxt = ST_GMUL;
      end
      ST_GMUL: begin
        state_nxt = ST_RND2;
      end
      ST_RND2: begin
        for (int i = 0; i < SECTIONS; i++) begin
          if (sec_r == SEC_W'(i)) begin
            xd_nxt[2*i+1] = xd_r[2*i];
            xd_nxt[2*i]   = sig_r;
            yd_nxt[2*i+1] = yd_r[2*i];
            yd_nxt[2*i]   = yv;
          end
        end
        sig_nxt = yv;
        if (sec_r == SEC_W'(SECTIONS - 1)) begin
          state_nxt = ST_OMUL;
        end else begin
          sec_nxt   = sec_r + SEC_W'(1);
          tap_nxt   = '0;
          state_nxt = ST_MAC;
        end
      end
      ST_OMUL: begin
        state_nxt = ST_ORND;
      end
      ST_ORND: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = out_conv(wide_t'(prod_r));
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sec_r       <= '0;
      tap_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 2*SECTIONS; i++) begin
        xd_r[i] <= '0;
        yd_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      sec_r       <= sec_nxt;
      tap_r       <= tap_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < 2*SECTIONS; i++) begin
        xd_r[i] <= xd_nxt[i];
        yd_r[i] <= yd_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    sig_r      <= sig_nxt;
    r_r        <= r_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
    if (prod_en) begin
      prod_r <= prod_nxt;
    end
  end

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_r[0] <= S0_NUM_RST;
      den_r[0] <= S0_DEN_RST;
      num_r[1] <= S1_NUM_RST;
      den_r[1] <= S1_DEN_RST;
      num_r[2] <= S2_NUM_RST;
      den_r[2] <= S2_DEN_RST;
      gain_r   <= GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_S0_NUM: num_r[0] <= cfg_wdata[47:0];
        CFG_S0_DEN: den_r[0] <= cfg_wdata[31:0];
        CFG_S1_NUM: num_r[1] <= cfg_wdata[47:0];
        CFG_S1_DEN: den_r[1] <= cfg_wdata[31:0];
        CFG_S2_NUM: num_r[2] <= cfg_wdata[47:0];
        CFG_S2_DEN: den_r[2] <= cfg_wdata[31:0];
        CFG_GAIN:   gain_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_MAC) && (tap_r == 3'd0) && (sec_r == '0))
    else $error("accepted item did not start at section 0, tap 0");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ORND) && out_valid_r && !out_ch.ready |=> (state_r == ST_ORND))
    else $error("result left before the output register freed");

  a_sec_range: assert property (@(posedge clk) disable iff (!rst_n)
    sec_r <= SEC_W'(SECTIONS - 1))
    else $error("section counter out of range");

  a_tap_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MAC) |-> (tap_r <= TAP_LAST))
    else $error("tap counter out of range");

endmodule
